// ===== sv/orpc_pkg.sv =====
package orpc_pkg;

    localparam int MAX_RECTANGLES = 64;
    localparam int IDX_W          = $clog2(MAX_RECTANGLES);
    localparam int ENTRY_W        = 6;
    localparam int CNT_W          = 7;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int S_DATA_W       = 296;
    localparam int M_DATA_W       = 176;

    // fracture conductivity in unsigned Q24.24
    localparam logic [47:0] FRAC_K_HIGH = 48'd167772160000;
    localparam logic [47:0] FRAC_K_LOW  = 48'd1678;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRACTURES_IN_USE   = 3'd0,
        REG_MATRIX_COND        = 3'd1,
        REG_HIGH_CONTRAST      = 3'd2,
        REG_FRACTURE_POROSITY  = 3'd3,
        REG_MATRIX_POROSITY    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0] n_in_use;
        logic [47:0]      matrix_k;
        logic             high_contrast;
        logic [16:0]      frac_por;
        logic [16:0]      matrix_por;
    } cfg_t;

    // input word as received
    typedef struct packed {
        op_t                  op;
        logic [ENTRY_W-1:0]   idx;
        logic signed [17:0]   cos_v;
        logic signed [17:0]   sin_v;
        logic signed [31:0]   cx;
        logic signed [31:0]   cy;
        logic [30:0]          len_a;
        logic [30:0]          len_b;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [31:0]   gx;
        logic signed [31:0]   gy;
    } raw_t;

    // word traveling down the cell chain
    typedef struct packed {
        op_t                  op;
        logic [ENTRY_W-1:0]   idx;
        logic signed [17:0]   cos_v;
        logic signed [17:0]   sin_v;
        logic signed [47:0]   off_a;
        logic signed [47:0]   off_b;
        logic [30:0]          len_a;
        logic [30:0]          len_b;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [31:0]   gx;
        logic signed [31:0]   gy;
        logic [CNT_W-1:0]     count;
    } item_t;

    typedef struct packed {
        logic signed [47:0] vel_y;
        logic signed [47:0] vel_x;
        logic [47:0]        conductivity;
        logic [16:0]        porosity;
        logic               too_many;
        logic               in_fracture;
        logic [CNT_W-1:0]   count;
    } result_t;

endpackage

// ===== sv/orpc_front.sv =====
module orpc_front
    import orpc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  logic  in_valid,
    input  raw_t  in_raw,
    output logic  out_valid,
    output item_t out_item
);

    logic               f1_valid_reg;
    raw_t               f1_raw_reg;
    logic signed [49:0] f1_ccx_reg;
    logic signed [49:0] f1_scy_reg;
    logic signed [49:0] f1_ccy_reg;
    logic signed [49:0] f1_scx_reg;
    logic               out_valid_reg;
    item_t              out_item_reg;
    item_t              out_item_next;

    logic signed [17:0] c_in;
    logic signed [17:0] s_in;
    logic signed [31:0] cx_in;
    logic signed [31:0] cy_in;
    logic signed [50:0] sum_a;
    logic signed [50:0] sum_b;

    assign c_in  = in_raw.cos_v;
    assign s_in  = in_raw.sin_v;
    assign cx_in = in_raw.cx;
    assign cy_in = in_raw.cy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg  <= in_valid;
            out_valid_reg <= f1_valid_reg;
        end
    end

    // center projections onto both axes of a new entry
    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_raw_reg   <= in_raw;
            f1_ccx_reg   <= 50'(c_in) * 50'(cx_in);
            f1_scy_reg   <= 50'(s_in) * 50'(cy_in);
            f1_ccy_reg   <= 50'(c_in) * 50'(cy_in);
            f1_scx_reg   <= 50'(s_in) * 50'(cx_in);
            out_item_reg <= out_item_next;
        end
    end

    always_comb begin
        sum_a = 51'(f1_ccx_reg) + 51'(f1_scy_reg);
        sum_b = 51'(f1_ccy_reg) - 51'(f1_scx_reg);
        out_item_next.op    = f1_raw_reg.op;
        out_item_next.idx   = f1_raw_reg.idx;
        out_item_next.cos_v = f1_raw_reg.cos_v;
        out_item_next.sin_v = f1_raw_reg.sin_v;
        // floor to Q32.16
        out_item_next.off_a = 48'(sum_a >>> 16);
        out_item_next.off_b = 48'(sum_b >>> 16);
        out_item_next.len_a = f1_raw_reg.len_a;
        out_item_next.len_b = f1_raw_reg.len_b;
        out_item_next.px    = f1_raw_reg.px;
        out_item_next.py    = f1_raw_reg.py;
        out_item_next.gx    = f1_raw_reg.gx;
        out_item_next.gy    = f1_raw_reg.gy;
        out_item_next.count = '0;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== sv/orpc_cell.sv =====
module orpc_cell
    import orpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [IDX_W-1:0] cell_id,
    input  logic [CNT_W-1:0] n_in_use,
    input  logic             in_valid,
    input  item_t            in_item,
    output logic             out_valid,
    output item_t            out_item
);

    // stored rectangle entry
    logic signed [17:0] ent_cos_reg;
    logic signed [17:0] ent_sin_reg;
    logic signed [47:0] ent_off_a_reg;
    logic signed [47:0] ent_off_b_reg;
    logic [30:0]        ent_len_a_reg;
    logic [30:0]        ent_len_b_reg;

    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic signed [49:0] s1_cpx_reg;
    logic signed [49:0] s1_spy_reg;
    logic signed [49:0] s1_cpy_reg;
    logic signed [49:0] s1_spx_reg;
    logic               out_valid_reg;
    item_t              out_item_reg;
    item_t              out_item_next;

    logic               wr_en;
    logic signed [31:0] px_in;
    logic signed [31:0] py_in;
    logic signed [50:0] proj_a;
    logic signed [50:0] proj_b;
    logic signed [64:0] diff_a;
    logic signed [64:0] diff_b;
    logic signed [49:0] two_d_a;
    logic signed [49:0] two_d_b;
    logic signed [49:0] lim_a;
    logic signed [49:0] lim_b;
    logic               in_rect;
    logic               active;
    logic               hit;

    assign px_in = in_item.px;
    assign py_in = in_item.py;
    assign wr_en = adv && in_valid && (in_item.op == OP_LOAD)
                   && (CNT_W'(in_item.idx) == CNT_W'(cell_id));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ent_cos_reg   <= in_item.cos_v;
            ent_sin_reg   <= in_item.sin_v;
            ent_off_a_reg <= in_item.off_a;
            ent_off_b_reg <= in_item.off_b;
            ent_len_a_reg <= in_item.len_a;
            ent_len_b_reg <= in_item.len_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg  <= in_item;
            s1_cpx_reg   <= 50'(ent_cos_reg) * 50'(px_in);
            s1_spy_reg   <= 50'(ent_sin_reg) * 50'(py_in);
            s1_cpy_reg   <= 50'(ent_cos_reg) * 50'(py_in);
            s1_spx_reg   <= 50'(ent_sin_reg) * 50'(px_in);
            out_item_reg <= out_item_next;
        end
    end

    // floor(p) - off equals floor(p - off * 2^16), so subtract before the shift
    always_comb begin
        proj_a  = 51'(s1_cpx_reg) + 51'(s1_spy_reg);
        proj_b  = 51'(s1_cpy_reg) - 51'(s1_spx_reg);
        diff_a  = 65'(proj_a) - 65'($signed({ent_off_a_reg, 16'b0}));
        diff_b  = 65'(proj_b) - 65'($signed({ent_off_b_reg, 16'b0}));
        two_d_a = {diff_a[64:16], 1'b0};
        two_d_b = {diff_b[64:16], 1'b0};
        lim_a   = $signed({19'b0, ent_len_a_reg});
        lim_b   = $signed({19'b0, ent_len_b_reg});
        in_rect = (two_d_a < lim_a) && (two_d_a > -lim_a)
                  && (two_d_b < lim_b) && (two_d_b > -lim_b);
        active  = CNT_W'(cell_id) < n_in_use;
        hit     = in_rect && active && (s1_item_reg.op == OP_QUERY);
        out_item_next       = s1_item_reg;
        out_item_next.count = s1_item_reg.count + CNT_W'(hit);
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== sv/orpc_back.sv =====
module orpc_back
    import orpc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    adv,
    input  cfg_t    cfg,
    input  logic    in_valid,
    input  item_t   in_item,
    output logic    out_valid,
    output result_t out_res
);

    logic             b1_valid_reg;
    op_t              b1_op_reg;
    logic [CNT_W-1:0] b1_count_reg;
    logic [16:0]      b1_por_reg;
    logic [47:0]      b1_k_reg;
    logic             b1_pos_x_reg;
    logic             b1_pos_y_reg;
    logic [55:0]      b1_hi_x_reg;
    logic [55:0]      b1_lo_x_reg;
    logic [55:0]      b1_hi_y_reg;
    logic [55:0]      b1_lo_y_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    result_t          out_res_next;

    logic             is_frac;
    logic [47:0]      k_sel;
    logic [16:0]      por_sel;
    logic [31:0]      mag_x;
    logic [31:0]      mag_y;

    // give the magnitude the sign opposite to the gradient, then saturate
    function automatic logic signed [47:0] sat_vel(input logic [55:0] p_hi,
                                                   input logic [55:0] p_lo,
                                                   input logic        pos);
        logic [63:0] mag;
        logic signed [47:0] r;
        mag = {p_hi, 8'b0} + 64'(p_lo >> 16);
        if (pos) begin
            if (mag > 64'h0000_8000_0000_0000) begin
                r = 48'sh8000_0000_0000;
            end else begin
                r = 48'(-mag);
            end
        end else begin
            if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
                r = 48'sh7FFF_FFFF_FFFF;
            end else begin
                r = mag[47:0];
            end
        end
        return r;
    endfunction

    always_comb begin
        is_frac = in_item.count != '0;
        if (is_frac) begin
            k_sel   = cfg.high_contrast ? FRAC_K_HIGH : FRAC_K_LOW;
            por_sel = cfg.frac_por;
        end else begin
            k_sel   = cfg.matrix_k;
            por_sel = cfg.matrix_por;
        end
        mag_x = in_item.gx[31] ? 32'(-in_item.gx) : 32'(in_item.gx);
        mag_y = in_item.gy[31] ? 32'(-in_item.gy) : 32'(in_item.gy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg  <= in_valid;
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_op_reg    <= in_item.op;
            b1_count_reg <= in_item.count;
            b1_por_reg   <= por_sel;
            b1_k_reg     <= k_sel;
            b1_pos_x_reg <= in_item.gx > 0;
            b1_pos_y_reg <= in_item.gy > 0;
            b1_hi_x_reg  <= 56'(mag_x) * 56'(k_sel[47:24]);
            b1_lo_x_reg  <= 56'(mag_x) * 56'(k_sel[23:0]);
            b1_hi_y_reg  <= 56'(mag_y) * 56'(k_sel[47:24]);
            b1_lo_y_reg  <= 56'(mag_y) * 56'(k_sel[23:0]);
            out_res_reg  <= out_res_next;
        end
    end

    always_comb begin
        out_res_next = '0;
        if (b1_op_reg == OP_QUERY) begin
            out_res_next.count        = b1_count_reg;
            out_res_next.in_fracture  = b1_count_reg != '0;
            out_res_next.too_many     = b1_count_reg > CNT_W'(2);
            out_res_next.porosity     = b1_por_reg;
            out_res_next.conductivity = b1_k_reg;
            out_res_next.vel_x        = sat_vel(b1_hi_x_reg, b1_lo_x_reg, b1_pos_x_reg);
            out_res_next.vel_y        = sat_vel(b1_hi_y_reg, b1_lo_y_reg, b1_pos_y_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_flag_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg.in_fracture == (out_res_reg.count != '0)))
        else $error("in_fracture disagrees with fracture_count");

    a_too_many_implies_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.too_many) |-> out_res_reg.in_fracture)
        else $error("too_many set outside any fracture");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg.count <= CNT_W'(MAX_RECTANGLES)))
        else $error("fracture_count beyond the number of cells");

    a_zero_k_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.conductivity == '0)
            |-> (out_res_reg.vel_x == '0 && out_res_reg.vel_y == '0))
        else $error("nonzero velocity with zero conductivity");

endmodule

// ===== sv/oriented_rectangle_point_classifier.sv =====
// Oriented rectangle point classifier.
// s_ channel takes one word per item; s_tuser selects load (0) or query (1).
// A load word writes rectangle entry entry_index; a query word gives a point
// and a pressure gradient. Every word, load or query, yields exactly one m_
// word: loads give all-zero fields, queries give the containing-entry count,
// the selected porosity and conductivity and the saturated velocity.
// Configuration registers must be written through cfg_wr_en/cfg_wr_index/
// cfg_wr_data while no word is in flight; the block itself does not enforce it.
// Words pass a front stage pair (center projections of a load), a chain of
// MAX_RECTANGLES cells of two stages each (one entry per cell, projection
// multiply then subtract and compare) and a back stage pair (velocity
// multiply, then saturate into the output register).
// Throughput: one word per cycle while m_tready allows; the whole pipe advances together.
// When m_tready is low with a word waiting, the pipe holds and s_tready
// drops; no word is lost. Reset clears all valid flags and sets the
// configuration registers to their defaults; stored entries stay undefined
// until loaded.
module oriented_rectangle_point_classifier
    import orpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index, cos_angle, sin_angle, center_x, center_y, length_a,
    // length_b, point_x, point_y, grad_x, grad_y
    input  logic [S_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fracture_count, in_fracture, too_many, porosity, conductivity,
    // velocity_x, velocity_y, zero fill
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    cfg_t    cfg_reg;
    raw_t    in_raw;
    logic    adv;
    logic    front_valid;
    item_t   front_item;
    logic    back_valid;
    result_t back_res;

    logic  chain_valid [0:MAX_RECTANGLES];
    item_t chain_item  [0:MAX_RECTANGLES];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.n_in_use      <= '0;
            cfg_reg.matrix_k      <= 48'd16777216;
            cfg_reg.high_contrast <= 1'b1;
            cfg_reg.frac_por      <= '0;
            cfg_reg.matrix_por    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_FRACTURES_IN_USE:  cfg_reg.n_in_use      <= cfg_wr_data[CNT_W-1:0];
                REG_MATRIX_COND:       cfg_reg.matrix_k      <= cfg_wr_data[47:0];
                REG_HIGH_CONTRAST:     cfg_reg.high_contrast <= cfg_wr_data[0];
                REG_FRACTURE_POROSITY: cfg_reg.frac_por      <= cfg_wr_data[16:0];
                REG_MATRIX_POROSITY:   cfg_reg.matrix_por    <= cfg_wr_data[16:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless a finished word waits at the output
    assign adv      = !back_valid || m_tready;
    assign s_tready = adv;

    // unpack the input word
    always_comb begin
        in_raw.op    = op_t'(s_tuser);
        in_raw.idx   = s_tdata[5:0];
        in_raw.cos_v = s_tdata[23:6];
        in_raw.sin_v = s_tdata[41:24];
        in_raw.cx    = s_tdata[73:42];
        in_raw.cy    = s_tdata[105:74];
        in_raw.len_a = s_tdata[136:106];
        in_raw.len_b = s_tdata[167:137];
        in_raw.px    = s_tdata[199:168];
        in_raw.py    = s_tdata[231:200];
        in_raw.gx    = s_tdata[263:232];
        in_raw.gy    = s_tdata[295:264];
    end

    orpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_raw    (in_raw),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    assign chain_valid[0] = front_valid;
    assign chain_item[0]  = front_item;

    // one cell per rectangle entry; each adds its hit to the running count
    for (genvar gi = 0; gi < MAX_RECTANGLES; gi++) begin : g_cell
        orpc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .cell_id   (IDX_W'(gi)),
            .n_in_use  (cfg_reg.n_in_use),
            .in_valid  (chain_valid[gi]),
            .in_item   (chain_item[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_item  (chain_item[gi+1])
        );
    end

    orpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (chain_valid[MAX_RECTANGLES]),
        .in_item   (chain_item[MAX_RECTANGLES]),
        .out_valid (back_valid),
        .out_res   (back_res)
    );

    assign m_tvalid = back_valid;
    assign m_tdata  = M_DATA_W'(back_res);

endmodule

// ===== bench/tb_oriented_rectangle_point_classifier.sv =====
`timescale 1ns / 100ps

module tb_oriented_rectangle_point_classifier;
    import orpc_pkg::*;

    // Input word layout on s_tdata, lowest field first (entry_index at bit 0).
    // A packed struct lists its first member in the top bits, so the order is reversed.
    typedef struct packed {
        logic signed [31:0] gy;
        logic signed [31:0] gx;
        logic signed [31:0] py;
        logic signed [31:0] px;
        logic [30:0]        len_b;
        logic [30:0]        len_a;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
        logic signed [17:0] sin_v;
        logic signed [17:0] cos_v;
        logic [5:0]         idx;
    } rect_word_t;

    // One row of the directed table: either a register write or one word,
    // optionally with a hand-computed result.
    typedef struct {
        bit          is_reg;
        cfg_reg_t    reg_sel;
        logic [47:0] reg_val;
        op_t         op;
        rect_word_t  word;
        bit          has_typed;
        result_t     typed_want;
    } stim_row_t;

    localparam logic [63:0] SAT_POS = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h0000_8000_0000_0000;
    localparam int          DRAIN_CYCLES = 2 * MAX_RECTANGLES + 12;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    oriented_rectangle_point_classifier dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Shadow copy of the configuration registers, reset values preloaded.
    logic [6:0]  cfg_in_use        = 7'd0;
    logic [47:0] cfg_matrix_k      = 48'd16777216;
    logic        cfg_high_contrast = 1'b1;
    logic [16:0] cfg_frac_por      = 17'd0;
    logic [16:0] cfg_matrix_por    = 17'd0;

    // Shadow copy of the rectangle store.
    longint ent_cos   [MAX_RECTANGLES];
    longint ent_sin   [MAX_RECTANGLES];
    longint ent_off_a [MAX_RECTANGLES];
    longint ent_off_b [MAX_RECTANGLES];
    longint ent_len_a [MAX_RECTANGLES];
    longint ent_len_b [MAX_RECTANGLES];

    result_t   expected_results[$];
    stim_row_t stim_table[$];
    int        mismatches   = 0;
    bit        calm_stretch = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop in case the pipe hangs.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Q32.32 down to Q48.16, rounding toward minus infinity.
    function automatic longint floor_q16(input longint v);
        return v >>> 16;
    endfunction

    // velocity = -K * g: magnitude truncated to Q24.24, sign flipped, saturated to 48 bits.
    function automatic logic [47:0] darcy_velocity(input logic [47:0] k, input longint g);
        logic [63:0] m;
        logic [63:0] mag;
        longint      r;
        m   = (g < 0) ? -g : g;
        mag = ((m * {40'd0, k[47:24]}) << 8) + ((m * {40'd0, k[23:0]}) >> 16);
        if (g > 0)
            r = (mag > SAT_NEG) ? -longint'(SAT_NEG) : -longint'(mag);
        else
            r = (mag > SAT_POS) ? longint'(SAT_POS) : longint'(mag);
        return r[47:0];
    endfunction

    // Advance the shadow store by one accepted word and return the word it yields.
    function automatic result_t predict_classification(input op_t op, input rect_word_t w);
        result_t     r;
        longint      c, s, px, py, da, db;
        logic [6:0]  n;
        logic [6:0]  hits;
        logic [47:0] k;
        r = '0;
        if (op == OP_LOAD) begin
            c = longint'($signed(w.cos_v));
            s = longint'($signed(w.sin_v));
            ent_cos[w.idx]   = c;
            ent_sin[w.idx]   = s;
            ent_off_a[w.idx] = floor_q16(c * $signed(w.cx) + s * $signed(w.cy));
            ent_off_b[w.idx] = floor_q16(c * $signed(w.cy) - s * $signed(w.cx));
            ent_len_a[w.idx] = longint'({1'b0, w.len_a});
            ent_len_b[w.idx] = longint'({1'b0, w.len_b});
            return r;
        end
        px   = longint'($signed(w.px));
        py   = longint'($signed(w.py));
        n    = (cfg_in_use > MAX_RECTANGLES) ? 7'(MAX_RECTANGLES) : cfg_in_use;
        hits = '0;
        for (int i = 0; i < n; i++) begin
            da = floor_q16(ent_cos[i] * px + ent_sin[i] * py) - ent_off_a[i];
            db = floor_q16(ent_cos[i] * py - ent_sin[i] * px) - ent_off_b[i];
            if (da < 0) da = -da;
            if (db < 0) db = -db;
            if (2 * da < ent_len_a[i] && 2 * db < ent_len_b[i])
                hits++;
        end
        if (hits != 0) begin
            k          = cfg_high_contrast ? FRAC_K_HIGH : FRAC_K_LOW;
            r.porosity = cfg_frac_por;
        end else begin
            k          = cfg_matrix_k;
            r.porosity = cfg_matrix_por;
        end
        r.count        = hits;
        r.in_fracture  = (hits != 0);
        r.too_many     = (hits > 2);
        r.conductivity = k;
        r.vel_x        = darcy_velocity(k, longint'($signed(w.gx)));
        r.vel_y        = darcy_velocity(k, longint'($signed(w.gy)));
        return r;
    endfunction

    function automatic void note_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Word builders for the directed table; unused fields stay zero.
    function automatic rect_word_t load_item(input logic [5:0] idx, input int c, input int s,
                                             input logic [31:0] cx, input logic [31:0] cy,
                                             input logic [30:0] la, input logic [30:0] lb);
        rect_word_t w;
        w       = '0;
        w.idx   = idx;
        w.cos_v = 18'(c);
        w.sin_v = 18'(s);
        w.cx    = cx;
        w.cy    = cy;
        w.len_a = la;
        w.len_b = lb;
        return w;
    endfunction

    function automatic rect_word_t query_item(input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] gx, input logic [31:0] gy);
        rect_word_t w;
        w    = '0;
        w.px = px;
        w.py = py;
        w.gx = gx;
        w.gy = gy;
        return w;
    endfunction

    // Hand-computed query result for a point outside every rectangle.
    function automatic result_t outside_result(input logic [16:0] por, input logic [47:0] k,
                                               input logic [47:0] vx, input logic [47:0] vy);
        result_t r;
        r              = '0;
        r.porosity     = por;
        r.conductivity = k;
        r.vel_x        = vx;
        r.vel_y        = vy;
        return r;
    endfunction

    function automatic void add_reg(input cfg_reg_t sel, input logic [47:0] val);
        stim_row_t row;
        row.is_reg     = 1'b1;
        row.reg_sel    = sel;
        row.reg_val    = val;
        row.op         = OP_LOAD;
        row.word       = '0;
        row.has_typed  = 1'b0;
        row.typed_want = '0;
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_word(input op_t op, input rect_word_t w, input bit has_typed,
                                     input result_t want);
        stim_row_t row;
        row.is_reg     = 1'b0;
        row.reg_sel    = REG_FRACTURES_IN_USE;
        row.reg_val    = '0;
        row.op         = op;
        row.word       = w;
        row.has_typed  = has_typed;
        row.typed_want = want;
        stim_table.insert(stim_table.size(), row);
    endfunction

    // Every bit of every field random, cosine and sine kept within +-1.0.
    function automatic rect_word_t random_word();
        rect_word_t w;
        w.idx   = 6'($urandom);
        w.cos_v = 18'($urandom_range(0, 131072) - 65536);
        w.sin_v = 18'($urandom_range(0, 131072) - 65536);
        w.cx    = $urandom;
        w.cy    = $urandom;
        w.len_a = 31'($urandom);
        w.len_b = 31'($urandom);
        w.px    = $urandom;
        w.py    = $urandom;
        w.gx    = $urandom;
        w.gy    = $urandom;
        return w;
    endfunction

    // Rectangle of 1 to 24 units, rotated at random, centered within 8 units of the origin,
    // so that several rectangles often overlap.
    function automatic rect_word_t cluster_rect(input logic [5:0] idx);
        rect_word_t w;
        real        ang;
        w       = random_word();
        ang     = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        w.idx   = idx;
        w.cos_v = 18'($rtoi(65536.0 * $cos(ang)));
        w.sin_v = 18'($rtoi(65536.0 * $sin(ang)));
        w.cx    = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        w.cy    = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        w.len_a = 31'($urandom_range(32'h0001_0000, 32'h0018_0000));
        w.len_b = 31'($urandom_range(32'h0001_0000, 32'h0018_0000));
        return w;
    endfunction

    // Point within 16 units of the origin; gradient either full range or modest.
    function automatic rect_word_t cluster_point();
        rect_word_t w;
        w    = random_word();
        w.px = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        w.py = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        if ($urandom_range(0, 1)) begin
            w.gx = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            w.gy = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end
        return w;
    endfunction

    // Offer one word, hold it until accepted, then queue what it should yield.
    // tready is sampled on the falling edge so the handshake decision never races the DUT.
    task automatic push_word(input op_t op, input rect_word_t w, input bit has_typed,
                             input result_t typed_want);
        result_t want;
        while (!calm_stretch && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= w;
        @(negedge aclk);
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
        want = predict_classification(op, w);
        if (has_typed)
            want = typed_want;
        expected_results.insert(expected_results.size(), want);
    endtask

    // Stop offering and wait until every word in flight has come out.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // One register write: enable pulsed high for one edge, then dropped before the shadow copy updates.
    task automatic write_reg(input cfg_reg_t sel, input logic [47:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= sel;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (sel)
            REG_FRACTURES_IN_USE:  cfg_in_use        = val[6:0];
            REG_MATRIX_COND:       cfg_matrix_k      = val[47:0];
            REG_HIGH_CONTRAST:     cfg_high_contrast = val[0];
            REG_FRACTURE_POROSITY: cfg_frac_por      = val[16:0];
            REG_MATRIX_POROSITY:   cfg_matrix_por    = val[16:0];
            default: ;
        endcase
    endtask

    // Receiver drops ready at random about 13 times in a hundred, never during the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm_stretch || ($urandom_range(0, 99) >= 13);
    end

    // Check each result word against the oldest expectation. Sample on the falling
    // edge: a word seen valid and ready here is taken at the next rising edge.
    always @(negedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing expected: %0h", $time, got);
            end else begin
                want = expected_results.pop_front();
                note_field("fracture_count", want.count, got.count);
                note_field("in_fracture", want.in_fracture, got.in_fracture);
                note_field("too_many", want.too_many, got.too_many);
                note_field("porosity", want.porosity, got.porosity);
                note_field("conductivity", want.conductivity, got.conductivity);
                note_field("velocity_x", want.vel_x, got.vel_x);
                note_field("velocity_y", want.vel_y, got.vel_y);
            end
        end
    end

    initial begin : stimulus
        logic [47:0] k_val;
        logic [6:0]  n_val;
        logic [16:0] fp_val;
        logic [16:0] mp_val;
        logic        hc_val;
        int          roll;

        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data  <= '0;

        // Directed table. Under reset configuration nothing is in use, so the
        // first queries read K = 1.0 and zero porosity straight from the defaults.
        add_word(OP_QUERY, query_item(32'h0, 32'h0, 32'h0, 32'h0), 1'b1,
                 outside_result(17'h0, 48'd16777216, 48'h0, 48'h0));
        // Extreme point and gradient: -g shifted into Q24.24, no saturation at K = 1.0.
        add_word(OP_QUERY, query_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000), 1'b1,
                 outside_result(17'h0, 48'd16777216, 48'hFF80_0000_0100, 48'h0080_0000_0000));
        // Loads always come back all zero.
        add_word(OP_LOAD, load_item(6'd0, 65536, 0, 32'h0, 32'h0, 31'h0010_0000,
                 31'h0010_0000), 1'b1, '0);
        add_word(OP_LOAD, load_item(6'd1, 0, 65536, 32'h0001_0000, 32'h0, 31'h0008_0000,
                 31'h0004_0000), 1'b1, '0);
        add_word(OP_LOAD, load_item(6'd2, -65536, 0, 32'h0, 32'h0, 31'h7FFF_FFFF,
                 31'h7FFF_FFFF), 1'b1, '0);
        add_word(OP_LOAD, load_item(6'd3, 46341, -46341, 32'h8000_0000, 32'h7FFF_FFFF,
                 31'h0002_0000, 31'h0002_0000), 1'b1, '0);
        // Zero-length sides never hold a point.
        add_word(OP_LOAD, load_item(6'd63, -65536, -65536, 32'h7FFF_FFFF, 32'h8000_0000,
                 31'h0, 31'h0), 1'b1, '0);
        // Porosity above one passes through unchanged; matrix K at its maximum.
        add_reg(REG_FRACTURES_IN_USE, 48'd4);
        add_reg(REG_HIGH_CONTRAST, 48'd1);
        add_reg(REG_FRACTURE_POROSITY, 48'h1_FFFF);
        add_reg(REG_MATRIX_POROSITY, 48'd65536);
        add_reg(REG_MATRIX_COND, 48'hFFFF_FFFF_FFFF);
        // Origin sits in three rectangles: more than two, too_many set.
        add_word(OP_QUERY, query_item(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000), 1'b0, '0);
        // Far corner is outside all; huge K saturates both velocity signs.
        add_word(OP_QUERY, query_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000), 1'b1,
                 outside_result(17'h1_0000, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000,
                                48'h7FFF_FFFF_FFFF));
        add_word(OP_QUERY, query_item(32'h0, 32'h0003_0000, 32'h0, 32'h0), 1'b0, '0);
        add_reg(REG_HIGH_CONTRAST, 48'd0);
        add_word(OP_QUERY, query_item(32'h000A_0000, 32'h0, 32'hFFFF_FFFF, 32'h1), 1'b0, '0);
        add_reg(REG_MATRIX_COND, 48'd0);
        add_reg(REG_FRACTURE_POROSITY, 48'd0);
        add_reg(REG_MATRIX_POROSITY, 48'h1_FFFF);
        add_word(OP_QUERY, query_item(32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000), 1'b0, '0);
        // Point exactly on the edge of entry 0 is outside it; one step in is inside.
        add_word(OP_LOAD, load_item(6'd0, 65536, 0, 32'h0, 32'h0, 31'h0004_0000,
                 31'h0004_0000), 1'b1, '0);
        add_word(OP_QUERY, query_item(32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0), 1'b0, '0);
        add_word(OP_QUERY, query_item(32'h0001_FFFF, 32'h0, 32'h0001_0000, 32'h0), 1'b0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; drain the pipe before every register write.
        for (int r = 0; r < stim_table.size(); r++) begin
            if (stim_table[r].is_reg) begin
                drain_pipe();
                write_reg(stim_table[r].reg_sel, stim_table[r].reg_val);
            end else begin
                push_word(stim_table[r].op, stim_table[r].word, stim_table[r].has_typed,
                          stim_table[r].typed_want);
            end
        end

        // Fill every entry in order before any query may look past entry 3.
        for (int e = 0; e < MAX_RECTANGLES; e++) begin
            push_word(OP_LOAD, cluster_rect(e[5:0]), 1'b0, '0);
            push_word(OP_QUERY, cluster_point(), 1'b0, '0);
        end

        // Random phases, each under its own register setting. Phase 1 writes an
        // in-use count past the store size, which must saturate.
        for (int p = 1; p <= 7; p++) begin
            case (p)
                1: begin
                    n_val = 7'd127; k_val = 48'hFFFF_FFFF_FFFF; hc_val = 1'b1;
                    fp_val = 17'h1_FFFF; mp_val = 17'h0;
                end
                2: begin
                    n_val = 7'd64; k_val = 48'h0; hc_val = 1'b0;
                    fp_val = 17'h0; mp_val = 17'h1_FFFF;
                end
                3: begin
                    n_val = 7'd0; k_val = 48'd16777216; hc_val = 1'b1;
                    fp_val = 17'h1_0000; mp_val = 17'h1_0000;
                end
                4: begin
                    n_val = 7'd1; k_val = 48'({$urandom, $urandom}); hc_val = 1'b0;
                    fp_val = 17'($urandom); mp_val = 17'($urandom);
                end
                default: begin
                    n_val  = 7'($urandom_range(2, 127));
                    k_val  = 48'({$urandom, $urandom});
                    hc_val = 1'($urandom);
                    fp_val = 17'($urandom_range(0, 17'h1_FFFF));
                    mp_val = 17'($urandom_range(0, 17'h1_FFFF));
                end
            endcase
            drain_pipe();
            write_reg(REG_FRACTURES_IN_USE, {41'd0, n_val});
            write_reg(REG_MATRIX_COND, k_val);
            write_reg(REG_HIGH_CONTRAST, {47'd0, hc_val});
            write_reg(REG_FRACTURE_POROSITY, {31'd0, fp_val});
            write_reg(REG_MATRIX_POROSITY, {31'd0, mp_val});

            // Phase 2 runs back to back with no idling on either side.
            calm_stretch = (p == 2);
            for (int j = 0; j < 118; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    push_word(OP_LOAD, cluster_rect(6'($urandom_range(0, 63))), 1'b0, '0);
                else if (roll < 88)
                    push_word(OP_QUERY, cluster_point(), 1'b0, '0);
                else
                    push_word(op_t'($urandom_range(0, 1)), random_word(), 1'b0, '0);
            end
            calm_stretch = 1'b0;
        end

        // Let the last words out, then allow one more pipe length for strays.
        drain_pipe();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
